// File: design/bsa_pkg.sv
// bsa_pkg: shared types and constants of the bitmap slot allocator
`default_nettype none

package bsa_pkg;

  localparam int BASE_SLOTS_DEF     = 64;
  localparam int OVERFLOW_SLOTS_DEF = 64;
  localparam int MAP_W              = 64;  // most slots one bitmap can hold
  localparam int IDX_W              = 6;   // bit index within one bitmap
  localparam int SLOT_W             = 7;   // slot number, overflow slots at 64 and up
  localparam int STATUS_W           = 2;
  localparam int LIVE_W             = 8;

  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    status_t           status;
    logic              first_overflow;
    logic [LIVE_W-1:0] live_total;
  } result_t;

endpackage

`default_nettype wire

// File: design/bsa_if.sv
// bsa_if: valid/ready channels for request and response items
`default_nettype none

interface bsa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  slot_in;

  modport source (output valid, output func, output slot_in, input ready);
  modport sink   (input valid, input func, input slot_in, output ready);
endinterface

interface bsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  slot_out;
  logic [1:0]  status;
  logic        first_overflow;
  logic [7:0]  live_total;

  modport source (output valid, output slot_out, output status, output first_overflow,
                  output live_total, input ready);
  modport sink   (input valid, input slot_out, input status, input first_overflow,
                  input live_total, output ready);
endinterface

`default_nettype wire

// File: design/bitmap_slot_allocator.sv
// bitmap_slot_allocator: top level, input register, allocation core, result register
//
//   channel | role | carries
//   --------+------+-----------------------------------------------------
//   req     | sink | func, slot_in              (acquire or release item)
//   rsp     | src  | slot_out, status, first_overflow, live_total
//
// one item per cycle sustained while rsp is ready; an item waits in the input register, then the result register
// the allocation work is one find-first-free pass over each bitmap between the
// input register and the result register, so the state is up to date for the
// very next item
// reset clears both bitmaps, the live count, the warning flag and both valid bits
// a stalled response holds in the result register; the input register takes an
// item while it is empty, or while the result register is free or being emptied
`default_nettype none

module bitmap_slot_allocator #(
  parameter int BASE_SLOTS     = bsa_pkg::BASE_SLOTS_DEF,
  parameter int OVERFLOW_SLOTS = bsa_pkg::OVERFLOW_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bsa_req_if.sink    req,
  bsa_rsp_if.source  rsp
);

  // input register
  logic              s_valid;
  bsa_pkg::item_t    s_item;

  // result register
  logic              o_valid;
  bsa_pkg::result_t  o_res;

  bsa_pkg::result_t  core_res;
  logic              out_free;
  logic              adv;

  // result register can load when empty or being drained this cycle
  assign out_free  = ~o_valid | rsp.ready;
  assign adv       = s_valid & out_free;
  assign req.ready = ~s_valid | out_free;

  bsa_core #(
    .BASE_SLOTS     (BASE_SLOTS),
    .OVERFLOW_SLOTS (OVERFLOW_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (s_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_item.func <= bsa_pkg::func_t'(req.func);
      s_item.slot <= req.slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res <= core_res;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.slot_out       = o_res.slot_out;
  assign rsp.status         = o_res.status;
  assign rsp.first_overflow = o_res.first_overflow;
  assign rsp.live_total     = o_res.live_total;

endmodule

`default_nettype wire

// File: design/bsa_find_free.sv
// bsa_find_free: lowest clear bit of a bitmap, as one-hot and as index
`default_nettype none

module bsa_find_free #(
  parameter int N = bsa_pkg::MAP_W
) (
  input  wire logic [N-1:0]              map,
  output logic                           found,
  output logic [N-1:0]                   onehot,
  output logic [bsa_pkg::IDX_W-1:0]      idx
);

  logic [N-1:0] free;

  // isolate lowest set bit of the free mask
  assign free   = ~map;
  assign onehot = free & (~free + N'(1));
  assign found  = |free;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | bsa_pkg::IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/bsa_core.sv
// bsa_core: allocation state and the per-item update logic
`default_nettype none

module bsa_core #(
  parameter int BASE_SLOTS     = bsa_pkg::BASE_SLOTS_DEF,
  parameter int OVERFLOW_SLOTS = bsa_pkg::OVERFLOW_SLOTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire bsa_pkg::item_t  item,
  output bsa_pkg::result_t     result
);

  logic [BASE_SLOTS-1:0]         base_map, base_map_next;
  logic [OVERFLOW_SLOTS-1:0]     overflow_map, overflow_map_next;
  logic [bsa_pkg::LIVE_W-1:0]    live_counter, live_counter_next;
  logic                          warned_flag, warned_flag_next;

  logic                          base_found, ovf_found;
  logic [BASE_SLOTS-1:0]         base_hot;
  logic [OVERFLOW_SLOTS-1:0]     ovf_hot;
  logic [bsa_pkg::IDX_W-1:0]     base_idx, ovf_idx;

  logic [bsa_pkg::MAP_W-1:0]     base_ext, ovf_ext, clr_mask;
  logic [bsa_pkg::IDX_W-1:0]     rel_idx;
  logic                          rel_ovf;

  bsa_find_free #(.N(BASE_SLOTS)) u_base_find (
    .map    (base_map),
    .found  (base_found),
    .onehot (base_hot),
    .idx    (base_idx)
  );

  bsa_find_free #(.N(OVERFLOW_SLOTS)) u_ovf_find (
    .map    (overflow_map),
    .found  (ovf_found),
    .onehot (ovf_hot),
    .idx    (ovf_idx)
  );

  assign rel_ovf  = item.slot[bsa_pkg::SLOT_W-1];
  assign rel_idx  = item.slot[bsa_pkg::IDX_W-1:0];
  assign clr_mask = bsa_pkg::MAP_W'(1) << rel_idx;

  // maps widened to full span; slots past the parameter read as free
  always_comb begin
    base_ext = '0;
    ovf_ext  = '0;
    base_ext[BASE_SLOTS-1:0]     = base_map;
    ovf_ext[OVERFLOW_SLOTS-1:0]  = overflow_map;
  end

  always_comb begin
    base_map_next      = base_map;
    overflow_map_next  = overflow_map;
    live_counter_next  = live_counter;
    warned_flag_next   = warned_flag;
    result.slot_out       = '0;
    result.status         = bsa_pkg::ST_OK;
    result.first_overflow = 1'b0;

    case (item.func)
      bsa_pkg::FUNC_ACQUIRE: begin
        if (base_found) begin
          base_map_next     = base_map | base_hot;
          live_counter_next = live_counter + bsa_pkg::LIVE_W'(1);
          result.slot_out   = {1'b0, base_idx};
        end else if (ovf_found) begin
          overflow_map_next     = overflow_map | ovf_hot;
          live_counter_next     = live_counter + bsa_pkg::LIVE_W'(1);
          result.slot_out       = {1'b1, ovf_idx};
          result.first_overflow = ~warned_flag;
          warned_flag_next      = 1'b1;
        end else begin
          result.status = bsa_pkg::ST_FULL;
        end
      end
      bsa_pkg::FUNC_RELEASE: begin
        if (!rel_ovf && base_ext[rel_idx]) begin
          base_map_next     = base_map & ~clr_mask[BASE_SLOTS-1:0];
          live_counter_next = live_counter - bsa_pkg::LIVE_W'(1);
        end else if (rel_ovf && ovf_ext[rel_idx]) begin
          overflow_map_next = overflow_map & ~clr_mask[OVERFLOW_SLOTS-1:0];
          live_counter_next = live_counter - bsa_pkg::LIVE_W'(1);
        end else begin
          result.status = bsa_pkg::ST_NOT_LIVE;
        end
      end
      default: begin
        result.status = bsa_pkg::ST_OK;
      end
    endcase

    result.live_total = live_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_map     <= '0;
      overflow_map <= '0;
      live_counter <= '0;
      warned_flag  <= 1'b0;
    end else if (step) begin
      base_map     <= base_map_next;
      overflow_map <= overflow_map_next;
      live_counter <= live_counter_next;
      warned_flag  <= warned_flag_next;
    end
  end

endmodule

`default_nettype wire

// File: design/bsa_checker.sv
// bsa_checker: port-level assertions for the slot allocator, bound to the top level
`default_nettype none

module bsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [6:0]  rsp_slot_out,
  input wire logic [1:0]  rsp_status,
  input wire logic        rsp_first_overflow,
  input wire logic [7:0]  rsp_live_total
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_out) &&
      $stable(rsp_status) && $stable(rsp_live_total) && $stable(rsp_first_overflow))
    else $error("response changed while stalled");

  // failed item grants nothing and raises no warning
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != bsa_pkg::ST_OK |->
      rsp_slot_out == '0 && !rsp_first_overflow)
    else $error("failed item carries a slot or warning");

  // warning only with a granted overflow slot
  a_warn_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_first_overflow |->
      rsp_slot_out[6] && rsp_status == bsa_pkg::ST_OK && rsp_live_total != '0)
    else $error("warning without an overflow grant");

  // live count never beyond all slots
  a_live_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_live_total[7] |-> rsp_live_total[6:0] == '0)
    else $error("live count out of range");

  // nothing offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_slot_out       (rsp.slot_out),
  .rsp_status         (rsp.status),
  .rsp_first_overflow (rsp.first_overflow),
  .rsp_live_total     (rsp.live_total)
);

`default_nettype wire
